### hw/rtl/s_curve_step_rate_profile_top_assert.svh
// Assertion macros shared by the step-rate profile RTL.
// Included by the controller and the datapath; depends on nothing else.
`ifndef S_CURVE_STEP_RATE_PROFILE_TOP_ASSERT_SVH
`define S_CURVE_STEP_RATE_PROFILE_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SCRP_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SCRP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/scrp_pkg.sv
// Shared types and constants of the step-rate profile block.
// Used by the register file, the controller, the datapath and the top level.
package scrp_pkg;

   // Axis modes carried by each input item.
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_MANUAL  = 2'd1;
   localparam logic [1:0] MODE_PROFILE = 2'd2;
   localparam logic [1:0] MODE_HOMING  = 2'd3;

   // Profile stages.
   localparam logic [2:0] STAGE_NONE     = 3'd0;
   localparam logic [2:0] STAGE_ACC_UP   = 3'd1;
   localparam logic [2:0] STAGE_ACC_DOWN = 3'd2;
   localparam logic [2:0] STAGE_CRUISE   = 3'd3;
   localparam logic [2:0] STAGE_DEC_UP   = 3'd4;
   localparam logic [2:0] STAGE_DEC_DOWN = 3'd5;
   localparam logic [2:0] STAGE_END      = 3'd6;

   // Configuration register indexes.
   localparam logic [2:0] REG_START_RATE  = 3'd0;
   localparam logic [2:0] REG_END_RATE    = 3'd1;
   localparam logic [2:0] REG_CRUISE_RATE = 3'd2;
   localparam logic [2:0] REG_JERK_STEP   = 3'd3;
   localparam logic [2:0] REG_ACCEL_LIMIT = 3'd4;
   localparam logic [2:0] REG_MOVE_PULSES = 3'd5;
   localparam logic [2:0] REG_HOMING_RATE = 3'd6;

   // Fixed rates and reset values.
   localparam logic [15:0] RATE_MAX         = 16'hFFFF;
   localparam logic [15:0] MANUAL_STEP      = 16'd50;
   localparam logic [15:0] JERK_RESET       = 16'd1;
   localparam logic [15:0] HOMING_RESET     = 16'd100;

   // Configuration register contents.
   typedef struct packed {
      logic [15:0] start_rate;
      logic [15:0] end_rate;
      logic [15:0] cruise_rate;
      logic [15:0] jerk_step;
      logic [19:0] accel_limit;
      logic [23:0] move_pulses;
      logic [15:0] homing_rate;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic prep;
      logic mul1;
      logic mul2;
      logic sum;
      logic upd;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ramp_run;
   } status_type;

endpackage

### hw/rtl/scrp_regs.sv
// Configuration register file of the step-rate profile block.
// Depends on scrp_pkg for the register indexes and the cfg_type struct.
module scrp_regs (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [23:0]      csr_wdata,
   output scrp_pkg::cfg_type cfg
);
   import scrp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Write decoder; indexes beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_START_RATE:  cfg_in.start_rate  = csr_wdata[15:0];
            REG_END_RATE:    cfg_in.end_rate    = csr_wdata[15:0];
            REG_CRUISE_RATE: cfg_in.cruise_rate = csr_wdata[15:0];
            REG_JERK_STEP:   cfg_in.jerk_step   = csr_wdata[15:0];
            REG_ACCEL_LIMIT: cfg_in.accel_limit = csr_wdata[19:0];
            REG_MOVE_PULSES: cfg_in.move_pulses = csr_wdata[23:0];
            REG_HOMING_RATE: cfg_in.homing_rate = csr_wdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Register storage with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_rate  <= '0;
         cfg_ff.end_rate    <= '0;
         cfg_ff.cruise_rate <= '0;
         cfg_ff.jerk_step   <= JERK_RESET;
         cfg_ff.accel_limit <= '0;
         cfg_ff.move_pulses <= '0;
         cfg_ff.homing_rate <= HOMING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/scrp_ctrl.sv
// Sequencer of the step-rate profile block: input and result handshakes and
// the order of datapath steps. Depends on scrp_pkg and the assertion header.
`include "s_curve_step_rate_profile_top_assert.svh"

module scrp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  scrp_pkg::status_type status,
   output scrp_pkg::cmd_type    cmd
);
   import scrp_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_MUL1 = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_SUM  = 3'd4;
   localparam logic [2:0] ST_UPD  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Next-state logic. Ramp stages run the multiply steps, all else goes
   // straight to the update.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_PREP;
         ST_PREP: state_in = status.ramp_run ? ST_MUL1 : ST_UPD;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_UPD;
         ST_UPD:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Step commands to the datapath.
   always_comb begin
      cmd.accept = accept;
      cmd.prep   = (state_ff == ST_PREP);
      cmd.mul1   = (state_ff == ST_MUL1);
      cmd.mul2   = (state_ff == ST_MUL2);
      cmd.sum    = (state_ff == ST_SUM);
      cmd.upd    = (state_ff == ST_UPD) && out_free;
   end

   // The result register is full from the update until the item is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.upd) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // A blocked result holds the sequencer in the update step.
   `SCRP_ASSERT_NEXT(a_upd_hold, clock, reset,
      state_ff == ST_UPD && rsp_valid_ff && !rsp_tready, state_ff == ST_UPD,
      "update step left while the result register was full")
   // Every update fills the result register.
   `SCRP_ASSERT_NEXT(a_upd_fills, clock, reset, cmd.upd, rsp_valid_ff,
      "update did not present a result item")
   // An accepted item always starts with the preparation step.
   `SCRP_ASSERT_NEXT(a_accept_prep, clock, reset, accept, state_ff == ST_PREP,
      "accepted item did not enter the preparation step")

endmodule

### hw/rtl/scrp_datapath.sv
// Datapath of the step-rate profile block: profile state, multipliers,
// saturation and the result register. Depends on scrp_pkg and the assertion header.
`include "s_curve_step_rate_profile_top_assert.svh"

module scrp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  scrp_pkg::cfg_type    cfg,
   input  scrp_pkg::cmd_type    cmd,
   output scrp_pkg::status_type status,
   input  logic [1:0]           axis_mode,
   input  logic                 begin_move,
   input  logic [23:0]          pulses_done,
   input  logic [7:0]           jog_grade,
   output logic [15:0]          step_rate,
   output logic                 drive_on,
   output logic [2:0]           ramp_stage
);
   import scrp_pkg::*;

   // Item fields latched at accept.
   logic [1:0]  mode_ff;
   logic [23:0] pulses_ff;
   logic [7:0]  grade_ff;

   // Profile state.
   logic [31:0] tc_ff, tc_in;
   logic [2:0]  stage_ff, stage_in;
   logic [31:0] accel_ff, accel_in;
   logic [15:0] rate_ff, rate_in;
   logic [15:0] rate_marks_ff [3];
   logic [15:0] rate_marks_in [3];
   logic [31:0] tick_marks_ff [3];
   logic [31:0] tick_marks_in [3];
   logic [23:0] ramp_ff, ramp_in;

   // Work registers of the multiply sequence.
   logic [31:0] d_ff;
   logic [47:0] jd_ff;
   logic [31:0] acc_ff;
   logic [63:0] p_ff;
   logic [63:0] q_ff;
   logic [47:0] r_ff;
   logic [61:0] jdh_ff;

   // Result register.
   logic [15:0] step_rate_ff;
   logic        drive_on_ff;
   logic [2:0]  ramp_stage_ff;

   logic [24:0]        budget_sum;
   logic               stage_cond;
   logic               ramp_up;
   logic [31:0]        mark_sel;
   logic [31:0]        acc_sat;
   logic [19:0]        acc_sub;
   logic [31:0]        mul_a;
   logic [79:0]        jdd;
   logic [62:0]        half_p;
   logic [16:0]        up_sum;
   logic [15:0]        rate_up;
   logic [15:0]        rate_dn;
   logic signed [64:0] acc_down_sum;
   logic signed [64:0] dec_down_sum;
   logic [15:0]        manual_rate;
   logic [15:0]        out_rate;

   // Saturate a signed sum to the 16-bit rate range.
   function automatic logic [15:0] clamp_rate(input logic signed [64:0] v);
      logic [15:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > 65'sd65535) begin
         r = RATE_MAX;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Stage conditions, from the profile state, the latched item fields and the configuration.
   assign budget_sum = {1'b0, pulses_ff} + {1'b0, ramp_ff};
   always_comb begin
      case (stage_ff) inside
         STAGE_ACC_UP, STAGE_DEC_UP: stage_cond = accel_ff < {12'b0, cfg.accel_limit};
         STAGE_ACC_DOWN:             stage_cond = accel_ff != '0;
         STAGE_CRUISE:               stage_cond = budget_sum < {1'b0, cfg.move_pulses};
         STAGE_DEC_DOWN:             stage_cond = rate_ff > cfg.end_rate;
         default:                    stage_cond = 1'b0;
      endcase
   end

   assign ramp_up = (stage_ff == STAGE_ACC_UP) || (stage_ff == STAGE_DEC_UP);
   assign status.ramp_run = (mode_ff == MODE_PROFILE) && stage_cond &&
      (ramp_up || stage_ff == STAGE_ACC_DOWN || stage_ff == STAGE_DEC_DOWN);

   // Tick mark that the elapsed count of this stage is measured from.
   always_comb begin
      case (stage_ff)
         STAGE_ACC_DOWN: mark_sel = tick_marks_ff[0];
         STAGE_DEC_UP:   mark_sel = tick_marks_ff[1];
         STAGE_DEC_DOWN: mark_sel = tick_marks_ff[2];
         default:        mark_sel = '0;
      endcase
   end

   // New acceleration: saturated jerk product on the way up, limit minus
   // it on the way down.
   assign acc_sat = (|jd_ff[47:32]) ? 32'hFFFF_FFFF : jd_ff[31:0];
   assign acc_sub = (jd_ff > {28'b0, cfg.accel_limit}) ? 20'd0 :
                    cfg.accel_limit - jd_ff[19:0];
   assign mul_a   = ramp_up ? acc_sat : {12'b0, cfg.accel_limit};

   // Jerk term jerk*d*d assembled from its two partial products.
   assign jdd = {16'b0, q_ff} + {r_ff, 32'b0};

   // Rate candidates of the four ramp stages.
   assign half_p  = p_ff[63:1];
   assign up_sum  = {1'b0, cfg.start_rate} + {1'b0, half_p[15:0]};
   assign rate_up = ((|half_p[62:16]) || up_sum[16]) ? RATE_MAX : up_sum[15:0];
   assign rate_dn = (half_p > {47'b0, rate_marks_ff[1]}) ? 16'd0 :
                    rate_marks_ff[1] - half_p[15:0];
   assign acc_down_sum = $signed({49'b0, rate_marks_ff[0]}) + $signed({1'b0, p_ff})
                       - $signed({3'b0, jdh_ff});
   assign dec_down_sum = $signed({49'b0, rate_marks_ff[2]}) - $signed({1'b0, p_ff})
                       + $signed({3'b0, jdh_ff});

   // Next profile state: begin request and tick at accept, stage work at update.
   always_comb begin
      tc_in         = tc_ff;
      stage_in      = stage_ff;
      accel_in      = accel_ff;
      rate_in       = rate_ff;
      rate_marks_in = rate_marks_ff;
      tick_marks_in = tick_marks_ff;
      ramp_in       = ramp_ff;
      if (cmd.accept) begin
         if (begin_move) begin
            stage_in = STAGE_ACC_UP;
            tc_in    = '0;
            accel_in = '0;
         end
         if (axis_mode == MODE_PROFILE) begin
            tc_in = tc_in + 32'd1;
         end
      end
      if (cmd.upd && mode_ff == MODE_PROFILE) begin
         case (stage_ff)
            STAGE_ACC_UP: begin
               if (stage_cond) begin
                  tick_marks_in[0] = tc_ff;
                  accel_in         = acc_ff;
                  rate_in          = rate_up;
                  rate_marks_in[0] = rate_up;
               end else begin
                  stage_in = STAGE_ACC_DOWN;
               end
            end
            STAGE_ACC_DOWN: begin
               if (stage_cond) begin
                  ramp_in  = pulses_ff;
                  accel_in = acc_ff;
                  rate_in  = clamp_rate(acc_down_sum);
               end else begin
                  stage_in = STAGE_CRUISE;
               end
            end
            STAGE_CRUISE: begin
               if (stage_cond) begin
                  tick_marks_in[1] = tc_ff;
                  rate_in          = cfg.cruise_rate;
                  rate_marks_in[1] = cfg.cruise_rate;
               end else begin
                  stage_in = STAGE_DEC_UP;
               end
            end
            STAGE_DEC_UP: begin
               if (stage_cond) begin
                  tick_marks_in[2] = tc_ff;
                  accel_in         = acc_ff;
                  rate_in          = rate_dn;
                  rate_marks_in[2] = rate_dn;
               end else begin
                  stage_in = STAGE_DEC_DOWN;
               end
            end
            STAGE_DEC_DOWN: begin
               if (stage_cond) begin
                  accel_in = acc_ff;
                  rate_in  = clamp_rate(dec_down_sum);
               end else begin
                  stage_in = STAGE_END;
               end
            end
            STAGE_END: rate_in = cfg.end_rate;
            default:   rate_in = rate_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff         <= '0;
         stage_ff      <= STAGE_NONE;
         accel_ff      <= '0;
         rate_ff       <= '0;
         rate_marks_ff <= '{default: '0};
         tick_marks_ff <= '{default: '0};
         ramp_ff       <= '0;
      end else begin
         tc_ff         <= tc_in;
         stage_ff      <= stage_in;
         accel_ff      <= accel_in;
         rate_ff       <= rate_in;
         rate_marks_ff <= rate_marks_in;
         tick_marks_ff <= tick_marks_in;
         ramp_ff       <= ramp_in;
      end
   end

   // Item fields.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff   <= axis_mode;
         pulses_ff <= pulses_done;
         grade_ff  <= jog_grade;
      end
   end

   // Multiply sequence: elapsed ticks, jerk product, then three products in
   // parallel, then the jerk term halved with saturation.
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         d_ff <= (stage_ff == STAGE_ACC_UP) ? tc_ff : tc_ff - mark_sel;
      end
      if (cmd.mul1) begin
         jd_ff <= 48'(d_ff) * 48'(cfg.jerk_step);
      end
      if (cmd.mul2) begin
         acc_ff <= ramp_up ? acc_sat : {12'b0, acc_sub};
         p_ff   <= 64'(mul_a) * 64'(d_ff);
         q_ff   <= 64'(jd_ff[31:0]) * 64'(d_ff);
         r_ff   <= 48'(jd_ff[47:32]) * 48'(d_ff);
      end
      if (cmd.sum) begin
         jdh_ff <= (|jdd[79:62]) ? {1'b1, 61'b0} : {1'b0, jdd[61:1]};
      end
   end

   // Result fields by mode.
   assign manual_rate = MANUAL_STEP + 16'(grade_ff) * MANUAL_STEP;
   always_comb begin
      unique case (mode_ff)
         MODE_MANUAL:  out_rate = manual_rate;
         MODE_PROFILE: out_rate = rate_in;
         MODE_HOMING:  out_rate = cfg.homing_rate;
         default:      out_rate = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         step_rate_ff  <= out_rate;
         drive_on_ff   <= (mode_ff != MODE_IDLE);
         ramp_stage_ff <= stage_in;
      end
   end

   assign step_rate  = step_rate_ff;
   assign drive_on   = drive_on_ff;
   assign ramp_stage = ramp_stage_ff;

   // The stage never runs past the held end stage.
   `SCRP_ASSERT_IMPL(a_stage_range, clock, reset, 1'b1, stage_ff <= STAGE_END,
      "profile stage out of range")
   // Jerk-down stages never raise acceleration above the limit.
   `SCRP_ASSERT_NEXT(a_accel_bound, clock, reset,
      cmd.upd && status.ramp_run &&
      (stage_ff == STAGE_ACC_DOWN || stage_ff == STAGE_DEC_DOWN),
      accel_ff <= {12'b0, cfg.accel_limit},
      "acceleration above limit after a jerk-down tick")
   // An idle item without a begin request leaves the tick count alone.
   `SCRP_ASSERT_NEXT(a_idle_tick, clock, reset,
      cmd.accept && axis_mode == MODE_IDLE && !begin_move, $stable(tc_ff),
      "tick count changed on an idle item")

endmodule

### hw/rtl/s_curve_step_rate_profile_top.sv
// Top level of the jerk-limited step-rate profile block for one stepper axis.
// Depends on scrp_pkg, scrp_regs, scrp_ctrl and scrp_datapath.
//
// One input item per control tick gives one result item with the step rate
// to drive: idle gives 0, manual mode 50+50*jog_grade, homing mode the
// homing rate, and profile mode runs a six-stage S-curve (jerk-up and
// jerk-down acceleration, cruise until the pulse budget minus the ramp
// pulses is used, jerk-up and jerk-down deceleration, then the end rate).
// A begin_move item restarts the profile at stage 1. After its accept an item
// passes the preparation and update steps; in an active acceleration or
// deceleration stage the registered elapsed-tick, multiply, partial-product
// sum and saturation steps of the ramp equations run between them. The next
// item is taken only once the sequencer is back in idle after the update.
// A result that the receiver does not take holds the sequencer in its update
// step.
// The result register lets the next item be accepted while a result waits.
// Configuration registers are written through the csr_ port; the user must write
// them only while no item is in flight, as the block itself does not enforce it.
module s_curve_step_rate_profile_top (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [23:0] pulses_done, [31:24] jog_grade
   input  logic [2:0]  req_tuser,   // [1:0] axis_mode, [2] begin_move
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] step_rate, [18:16] ramp_stage, rest zero
   output logic [0:0]  rsp_tuser,   // [0] drive_on
   // Configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import scrp_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic [15:0] step_rate;
   logic        drive_on;
   logic [2:0]  ramp_stage;

   // Configuration registers.
   scrp_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Step sequencer and handshakes.
   scrp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Profile state and arithmetic.
   scrp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .axis_mode   (req_tuser[1:0]),
      .begin_move  (req_tuser[2]),
      .pulses_done (req_tdata[23:0]),
      .jog_grade   (req_tdata[31:24]),
      .step_rate   (step_rate),
      .drive_on    (drive_on),
      .ramp_stage  (ramp_stage)
   );

   // Result packing.
   assign rsp_tdata = {5'b0, ramp_stage, step_rate};
   assign rsp_tuser = drive_on;

endmodule
